### hw/rtl/periodic_pwl_interpolator_core_macros.svh
// Assertion macros used by the periodic interpolator core.
`ifndef PERIODIC_PWL_INTERPOLATOR_CORE_MACROS_SVH
`define PERIODIC_PWL_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PPI_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define PPI_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPI_ASSERT_IMPL(label, ck, rn, ante, cons, msg)
`define PPI_ASSERT_NEXT(label, ck, rn, ante, cons, msg)
`endif
`endif

### hw/rtl/ppi_pkg.sv
// Types, constants and helpers for the periodic piecewise-linear interpolator.
package ppi_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int VAL_W          = 32;
    localparam int CNT_CFG_W      = 7;
    localparam int IDX_IN_W       = 6;
    localparam int CFG_IDX_W      = 1;
    localparam int ALU_W          = 36;
    localparam int STEP_W         = 5;

    localparam logic [STEP_W-1:0] STEP_LAST = '1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD      = 1'b0,
        CFG_POINT_COUNT = 1'b1
    } ppi_cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SEARCH,
        ST_FETCH,
        ST_WRAP,
        ST_SPAN,
        ST_DT,
        ST_CLAMP,
        ST_DV,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } ppi_state_t;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } ppi_alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
        logic             zero;
    } ppi_alu_rsp_t;

    function automatic logic [ALU_W-1:0] zx32(logic [31:0] v);
        return {{(ALU_W-32){1'b0}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] sx32(logic [31:0] v);
        return {{(ALU_W-32){v[31]}}, v};
    endfunction

endpackage

### hw/rtl/ppi_alu.sv
// Shared add/subtract unit with sign and zero flags.
module ppi_alu
(
    input  ppi_pkg::ppi_alu_req_t req,
    output ppi_pkg::ppi_alu_rsp_t rsp
);

    logic [ppi_pkg::ALU_W-1:0] b_op;
    logic [ppi_pkg::ALU_W-1:0] sum;

    assign b_op     = req.sub ? ~req.b : req.b;
    assign sum      = req.a + b_op + ppi_pkg::ALU_W'(req.sub);
    assign rsp.sum  = sum;
    assign rsp.neg  = sum[ppi_pkg::ALU_W-1];
    assign rsp.zero = (sum == '0);

endmodule

### hw/rtl/ppi_table.sv
// Breakpoint table: one write port, one registered read port.
module ppi_table
#(
    parameter int MAX_POINTS = ppi_pkg::MAX_POINTS_DEF,
    parameter int IDX_W      = $clog2(MAX_POINTS)
)
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [IDX_W-1:0]            waddr,
    input  logic [ppi_pkg::TIME_W-1:0]  wtime,
    input  logic [ppi_pkg::VAL_W-1:0]   wvalue,
    input  logic [IDX_W-1:0]            raddr,
    output logic [ppi_pkg::TIME_W-1:0]  rtime,
    output logic [ppi_pkg::VAL_W-1:0]   rvalue
);

    localparam int WORD_W = ppi_pkg::TIME_W + ppi_pkg::VAL_W;

    logic [WORD_W-1:0] mem [MAX_POINTS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wtime, wvalue};
        end
        rdata_reg <= mem[raddr];
    end

    assign rtime  = rdata_reg[WORD_W-1:ppi_pkg::VAL_W];
    assign rvalue = rdata_reg[ppi_pkg::VAL_W-1:0];

endmodule

### hw/rtl/periodic_pwl_interpolator_core.sv
// Top level of the periodic piecewise-linear interpolator.
//
// Usage: a beat on the command channel is taken when start is high and busy
// is low. kind selects a load (write entry_index with point_time and
// point_value) or a query (return level at point_time). A load gives no
// result and does not raise busy. A query raises busy and, when finished,
// shows level for exactly one cycle with done high. The receiver cannot
// stall, so level must be captured then.
// A query runs 32 restoring steps for the modulo by period (skipped for a
// zero period), one table read per entry in the bracket search, the setup
// steps, 32 shift-add multiply steps and 32 restoring divide steps. All of
// them share one 36-bit adder, so one query is in flight at a time. Exact
// hits and degenerate spans end after the search and setup.
// Registers period and point_count are written through the cfg channel,
// which is always ready. The user must write them only while the block is
// idle; the block itself does not enforce this.
// Reset clears the sequencer, sets period and point_count to 1 and leaves
// the breakpoint table unwritten; there is no clearing pass.
module periodic_pwl_interpolator_core
#(
    parameter int MAX_POINTS = ppi_pkg::MAX_POINTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [ppi_pkg::IDX_IN_W-1:0]      entry_index,
    input  logic [ppi_pkg::TIME_W-1:0]        point_time,
    input  logic signed [ppi_pkg::VAL_W-1:0]  point_value,
    output logic                              done,
    output logic signed [ppi_pkg::VAL_W-1:0]  level,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CW     = IDX_W + 1;
    localparam int AW     = ppi_pkg::ALU_W;
    localparam int P_W    = 65;

    ppi_pkg::ppi_state_t state_reg, state_next;

    logic [ppi_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [CW-1:0]                 rd_k_reg, rd_k_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic                          wrap_lo_reg, wrap_lo_next;
    logic                          done_reg, done_next;
    logic [31:0]                   period_reg;
    logic [ppi_pkg::CNT_CFG_W-1:0] point_count_reg;

    logic [31:0]    t_reg, t_next;
    logic [31:0]    prev_time_reg, prev_time_next;
    logic [31:0]    prev_val_reg, prev_val_next;
    logic [31:0]    e0_time_reg, e0_time_next;
    logic [31:0]    e0_val_reg, e0_val_next;
    logic [AW-1:0]  lt_reg, lt_next;
    logic [AW-1:0]  ht_reg, ht_next;
    logic [31:0]    lv_reg, lv_next;
    logic [31:0]    hv_reg, hv_next;
    logic [AW-1:0]  span_reg, span_next;
    logic [AW-1:0]  dt_reg, dt_next;
    logic [AW-1:0]  dv_reg, dv_next;
    logic [P_W-1:0] p_reg, p_next;
    logic [31:0]    level_reg, level_next;

    ppi_pkg::ppi_alu_req_t alu_req;
    ppi_pkg::ppi_alu_rsp_t alu_rsp;

    logic             load_we;
    logic [31:0]      idx32;
    logic [31:0]      pc32;
    logic [31:0]      n_clamp;
    logic [CW-1:0]    n_m1;
    logic [IDX_W-1:0] raddr;
    logic [31:0]      rtime;
    logic [31:0]      rvalue;
    logic [32:0]      mod_r2;
    logic [31:0]      mod_rnew;
    logic [33:0]      div_r2;
    logic [32:0]      div_rnew;
    logic [31:0]      mag;

    assign busy      = (state_reg != ppi_pkg::ST_IDLE);
    assign done      = done_reg;
    assign level     = level_reg;
    assign cfg_ready = 1'b1;

    assign idx32   = 32'(entry_index);
    assign load_we = start && !busy && (kind == ppi_pkg::KIND_LOAD)
                     && (idx32 < 32'(MAX_POINTS));

    // Point count 0 acts as 1 and counts above the table depth saturate.
    assign pc32    = 32'(point_count_reg);
    assign n_clamp = (pc32 == 32'd0) ? 32'd1 :
                     (pc32 > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : pc32;
    assign n_m1    = n_reg - CW'(1);

    ppi_table
    #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    )
    u_table
    (
        .clk    (clk),
        .we     (load_we),
        .waddr  (idx32[IDX_W-1:0]),
        .wtime  (point_time),
        .wvalue (point_value),
        .raddr  (raddr),
        .rtime  (rtime),
        .rvalue (rvalue)
    );

    ppi_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Restoring step operands for the modulo and divide passes.
    assign mod_r2   = {p_reg[63:32], p_reg[31]};
    assign mod_rnew = alu_rsp.neg ? mod_r2[31:0] : alu_rsp.sum[31:0];
    assign div_r2   = {p_reg[64:32], p_reg[31]};
    assign div_rnew = alu_rsp.neg ? div_r2[32:0] : alu_rsp.sum[32:0];
    assign mag      = dv_reg[AW-1] ? alu_rsp.sum[31:0] : dv_reg[31:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rd_k_next      = rd_k_reg;
        rd_vld_next    = rd_vld_reg;
        wrap_lo_next   = wrap_lo_reg;
        done_next      = 1'b0;
        t_next         = t_reg;
        prev_time_next = prev_time_reg;
        prev_val_next  = prev_val_reg;
        e0_time_next   = e0_time_reg;
        e0_val_next    = e0_val_reg;
        lt_next        = lt_reg;
        ht_next        = ht_reg;
        lv_next        = lv_reg;
        hv_next        = hv_reg;
        span_next      = span_reg;
        dt_next        = dt_reg;
        dv_next        = dv_reg;
        p_next         = p_reg;
        level_next     = level_reg;
        raddr          = k_reg[IDX_W-1:0];
        alu_req.sub    = 1'b0;
        alu_req.a      = '0;
        alu_req.b      = '0;

        unique case (state_reg)
            ppi_pkg::ST_IDLE:
            begin
                if (start && (kind == ppi_pkg::KIND_QUERY))
                begin
                    t_next      = point_time;
                    n_next      = n_clamp[CW-1:0];
                    p_next      = {33'd0, point_time};
                    cnt_next    = '0;
                    k_next      = '0;
                    rd_vld_next = 1'b0;
                    state_next  = (period_reg != 32'd0) ? ppi_pkg::ST_MOD
                                                        : ppi_pkg::ST_SEARCH;
                end
            end

            ppi_pkg::ST_MOD:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(mod_r2);
                alu_req.b   = ppi_pkg::zx32(period_reg);
                p_next      = {1'b0, mod_rnew, p_reg[30:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == ppi_pkg::STEP_LAST)
                begin
                    t_next     = mod_rnew;
                    state_next = ppi_pkg::ST_SEARCH;
                end
            end

            ppi_pkg::ST_SEARCH:
            begin
                // Reads are issued one entry per cycle; the compare runs in the
                // next cycle on the registered read data.
                if (k_reg < n_reg)
                begin
                    k_next      = k_reg + CW'(1);
                    rd_k_next   = k_reg;
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (rd_vld_reg)
                begin
                    alu_req.sub = 1'b1;
                    alu_req.a   = ppi_pkg::zx32(rtime);
                    alu_req.b   = ppi_pkg::zx32(t_reg);
                    if (rd_k_reg == CW'(0))
                    begin
                        e0_time_next = rtime;
                        e0_val_next  = rvalue;
                    end
                    if (!alu_rsp.neg)
                    begin
                        ht_next = ppi_pkg::zx32(rtime);
                        hv_next = rvalue;
                        if (rd_k_reg == CW'(0))
                        begin
                            state_next = ppi_pkg::ST_FETCH;
                        end
                        else
                        begin
                            lt_next    = ppi_pkg::zx32(prev_time_reg);
                            lv_next    = prev_val_reg;
                            state_next = ppi_pkg::ST_SPAN;
                        end
                    end
                    else
                    begin
                        prev_time_next = rtime;
                        prev_val_next  = rvalue;
                        if (rd_k_reg == n_m1)
                        begin
                            // Past the last point: run toward the first one
                            // a period later.
                            lt_next      = ppi_pkg::zx32(rtime);
                            lv_next      = rvalue;
                            wrap_lo_next = 1'b0;
                            state_next   = ppi_pkg::ST_WRAP;
                        end
                    end
                end
            end

            ppi_pkg::ST_FETCH:
            begin
                raddr        = n_m1[IDX_W-1:0];
                wrap_lo_next = 1'b1;
                state_next   = ppi_pkg::ST_WRAP;
            end

            ppi_pkg::ST_WRAP:
            begin
                alu_req.b = ppi_pkg::zx32(period_reg);
                if (wrap_lo_reg)
                begin
                    // Before the first point: the last point one period back.
                    alu_req.sub = 1'b1;
                    alu_req.a   = ppi_pkg::zx32(rtime);
                    lt_next     = alu_rsp.sum;
                    lv_next     = rvalue;
                end
                else
                begin
                    alu_req.a = ppi_pkg::zx32(e0_time_reg);
                    ht_next   = alu_rsp.sum;
                    hv_next   = e0_val_reg;
                end
                state_next = ppi_pkg::ST_SPAN;
            end

            ppi_pkg::ST_SPAN:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ht_reg;
                alu_req.b   = lt_reg;
                priority if (ht_reg == ppi_pkg::zx32(t_reg))
                begin
                    level_next = hv_reg;
                    done_next  = 1'b1;
                    state_next = ppi_pkg::ST_IDLE;
                end
                else if ((lt_reg == ppi_pkg::zx32(t_reg)) || alu_rsp.neg || alu_rsp.zero)
                begin
                    level_next = lv_reg;
                    done_next  = 1'b1;
                    state_next = ppi_pkg::ST_IDLE;
                end
                else
                begin
                    span_next  = alu_rsp.sum;
                    state_next = ppi_pkg::ST_DT;
                end
            end

            ppi_pkg::ST_DT:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ppi_pkg::zx32(t_reg);
                alu_req.b   = lt_reg;
                dt_next     = alu_rsp.neg ? '0 : alu_rsp.sum;
                state_next  = ppi_pkg::ST_CLAMP;
            end

            ppi_pkg::ST_CLAMP:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = dt_reg;
                alu_req.b   = span_reg;
                if (!alu_rsp.neg && !alu_rsp.zero)
                begin
                    dt_next = span_reg;
                end
                state_next = ppi_pkg::ST_DV;
            end

            ppi_pkg::ST_DV:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ppi_pkg::sx32(hv_reg);
                alu_req.b   = ppi_pkg::sx32(lv_reg);
                dv_next     = alu_rsp.sum;
                state_next  = ppi_pkg::ST_ABS;
            end

            ppi_pkg::ST_ABS:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = '0;
                alu_req.b   = dv_reg;
                p_next      = {33'd0, mag};
                cnt_next    = '0;
                state_next  = ppi_pkg::ST_MUL;
            end

            ppi_pkg::ST_MUL:
            begin
                // Shift-add: add the offset into the high half when the
                // multiplier bit leaving at the bottom is set.
                alu_req.a = AW'(p_reg[64:32]);
                alu_req.b = p_reg[0] ? dt_reg : '0;
                p_next    = {alu_rsp.sum[33:0], p_reg[31:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ppi_pkg::STEP_LAST)
                begin
                    state_next = ppi_pkg::ST_DIV;
                end
            end

            ppi_pkg::ST_DIV:
            begin
                // The high half already sits below the span, so 32 steps give
                // the whole quotient in the low half.
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(div_r2);
                alu_req.b   = span_reg;
                p_next      = {div_rnew, p_reg[30:0], !alu_rsp.neg};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == ppi_pkg::STEP_LAST)
                begin
                    state_next = ppi_pkg::ST_FIN;
                end
            end

            ppi_pkg::ST_FIN:
            begin
                alu_req.sub = dv_reg[AW-1];
                alu_req.a   = ppi_pkg::sx32(lv_reg);
                alu_req.b   = ppi_pkg::zx32(p_reg[31:0]);
                level_next  = alu_rsp.sum[31:0];
                done_next   = 1'b1;
                state_next  = ppi_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = ppi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ppi_pkg::ST_IDLE;
            cnt_reg         <= '0;
            n_reg           <= CW'(1);
            k_reg           <= '0;
            rd_k_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            wrap_lo_reg     <= 1'b0;
            done_reg        <= 1'b0;
            period_reg      <= 32'd1;
            point_count_reg <= ppi_pkg::CNT_CFG_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
            rd_k_reg    <= rd_k_next;
            rd_vld_reg  <= rd_vld_next;
            wrap_lo_reg <= wrap_lo_next;
            done_reg    <= done_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ppi_pkg::CFG_PERIOD:      period_reg      <= cfg_data;
                    ppi_pkg::CFG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        prev_time_reg <= prev_time_next;
        prev_val_reg  <= prev_val_next;
        e0_time_reg   <= e0_time_next;
        e0_val_reg    <= e0_val_next;
        lt_reg        <= lt_next;
        ht_reg        <= ht_next;
        lv_reg        <= lv_next;
        hv_reg        <= hv_next;
        span_reg      <= span_next;
        dt_reg        <= dt_next;
        dv_reg        <= dv_next;
        p_reg         <= p_next;
        level_reg     <= level_next;
    end

`include "periodic_pwl_interpolator_core_macros.svh"

    `PPI_ASSERT_NEXT(a_query_starts, clk, rst_n, start && !busy && kind == ppi_pkg::KIND_QUERY, busy, "query beat did not start the sequencer")
    `PPI_ASSERT_NEXT(a_load_silent, clk, rst_n, start && !busy && kind == ppi_pkg::KIND_LOAD, !done, "load beat produced a result")
    `PPI_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "result strobe while sequencer busy")
    `PPI_ASSERT_IMPL(a_div_rem, clk, rst_n, state_reg == ppi_pkg::ST_DIV, p_reg[64:32] < span_reg[32:0], "divide remainder reached span")
    `PPI_ASSERT_IMPL(a_search_bound, clk, rst_n, state_reg == ppi_pkg::ST_SEARCH, k_reg <= n_reg, "search ran past point count")

endmodule
